FILE: hw/rtl/lr_pkg.sv
// Shared types and constants for the line rasterizer.
// Holds the item structs, the command passed from front to back, and the codes.
// Has no dependencies.
package lr_pkg;

    localparam int COORD_BITS     = 10;
    localparam int COLOR_BITS     = 16;
    localparam int ERR_BITS       = COORD_BITS + 2;
    localparam int LEFT_BITS      = COORD_BITS + 1;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_NEXT  = 1'b1;

    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_INC  = 2'b01;
    localparam logic [1:0] STEP_DEC  = 2'b11;

    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [COLOR_BITS-1:0] pen_color;
    } req_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [COLOR_BITS-1:0] point_color;
        logic                  is_last;
    } pix_item_t;

    typedef struct packed {
        logic                  is_start;
        logic [COORD_BITS-1:0] start_col;
        logic [COORD_BITS-1:0] start_row;
        logic [1:0]            step_col;
        logic [1:0]            step_row;
        logic [COORD_BITS-1:0] abs_dx;
        logic [COORD_BITS-1:0] abs_dy;
        logic [COORD_BITS-1:0] span;
        logic [COLOR_BITS-1:0] color;
    } lr_cmd_t;

endpackage

FILE: hw/rtl/lr_front.sv
// Front part of the line rasterizer: classifies each item and works out the line setup.
// Produces a command with step codes, absolute deltas and span for the queue.
// Depends on lr_pkg.
module lr_front (
    input  lr_pkg::req_item_t req,
    output lr_pkg::lr_cmd_t   cmd_out
);

    logic [1:0]                    step_col;
    logic [1:0]                    step_row;
    logic [lr_pkg::COORD_BITS-1:0] abs_dx;
    logic [lr_pkg::COORD_BITS-1:0] abs_dy;

    always_comb
    begin
        priority if (req.x_end > req.x_start)
        begin
            step_col = lr_pkg::STEP_INC;
            abs_dx   = req.x_end - req.x_start;
        end
        else if (req.x_end < req.x_start)
        begin
            step_col = lr_pkg::STEP_DEC;
            abs_dx   = req.x_start - req.x_end;
        end
        else
        begin
            step_col = lr_pkg::STEP_NONE;
            abs_dx   = '0;
        end

        priority if (req.y_end > req.y_start)
        begin
            step_row = lr_pkg::STEP_INC;
            abs_dy   = req.y_end - req.y_start;
        end
        else if (req.y_end < req.y_start)
        begin
            step_row = lr_pkg::STEP_DEC;
            abs_dy   = req.y_start - req.y_end;
        end
        else
        begin
            step_row = lr_pkg::STEP_NONE;
            abs_dy   = '0;
        end
    end

    always_comb
    begin
        cmd_out.is_start  = (req.action == lr_pkg::ACTION_START);
        cmd_out.start_col = req.x_start;
        cmd_out.start_row = req.y_start;
        cmd_out.step_col  = step_col;
        cmd_out.step_row  = step_row;
        cmd_out.abs_dx    = abs_dx;
        cmd_out.abs_dy    = abs_dy;
        cmd_out.span      = (abs_dx > abs_dy) ? abs_dx : abs_dy;
        cmd_out.color     = req.pen_color;
    end

endmodule

FILE: hw/rtl/lr_queue.sv
// Short command queue between the front and back parts of the line rasterizer.
// A register file of DEPTH entries with read and write pointers and a fill count.
// Depends on lr_pkg.
module lr_queue #(
    parameter int DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lr_pkg::lr_cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output lr_pkg::lr_cmd_t head_cmd
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR   = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] DEPTH_CNT  = COUNT_W'(DEPTH);

    lr_pkg::lr_cmd_t    entry_mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_CNT)
        else $error("queue fill count exceeds its depth");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && (count_reg == '0)))
        else $error("queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue pushed while full");

endmodule

FILE: hw/rtl/lr_back.sv
// Back part of the line rasterizer: holds the line state and steps one pixel per next item on an active line.
// Error accumulators pick the axis moves; an output register parts it from the receiver.
// Depends on lr_pkg.
module lr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  lr_pkg::lr_cmd_t   head_cmd,
    output logic              pop,
    output logic              pix_valid,
    input  logic              pix_stall,
    output lr_pkg::pix_item_t pix
);

    logic                          busy_reg,     busy_next;
    logic [lr_pkg::COORD_BITS-1:0] cur_col_reg,  cur_col_next;
    logic [lr_pkg::COORD_BITS-1:0] cur_row_reg,  cur_row_next;
    logic [1:0]                    step_col_reg, step_col_next;
    logic [1:0]                    step_row_reg, step_row_next;
    logic [lr_pkg::COORD_BITS-1:0] abs_dx_reg,   abs_dx_next;
    logic [lr_pkg::COORD_BITS-1:0] abs_dy_reg,   abs_dy_next;
    logic [lr_pkg::COORD_BITS-1:0] span_reg,     span_next;
    logic [lr_pkg::ERR_BITS-1:0]   err_col_reg,  err_col_next;
    logic [lr_pkg::ERR_BITS-1:0]   err_row_reg,  err_row_next;
    logic [lr_pkg::LEFT_BITS-1:0]  left_reg,     left_next;
    logic [lr_pkg::COLOR_BITS-1:0] color_reg,    color_next;
    logic                          out_valid_reg, out_valid_next;
    lr_pkg::pix_item_t             out_reg,       out_next;

    logic                          out_free;
    logic                          emit;
    logic [lr_pkg::ERR_BITS-1:0]   sum_col;
    logic [lr_pkg::ERR_BITS-1:0]   sum_row;
    logic [lr_pkg::ERR_BITS-1:0]   span_ext;

    function automatic logic [lr_pkg::COORD_BITS-1:0] apply_step(
        input logic [lr_pkg::COORD_BITS-1:0] pos,
        input logic [1:0]                    step
    );
        logic [lr_pkg::COORD_BITS-1:0] res;
        unique case (step)
            lr_pkg::STEP_INC: res = pos + 1'b1;
            lr_pkg::STEP_DEC: res = pos - 1'b1;
            default:          res = pos;
        endcase
        return res;
    endfunction

    assign out_free  = !out_valid_reg || !pix_stall;
    assign pop       = head_valid && (head_cmd.is_start || !busy_reg || out_free);
    assign emit      = pop && !head_cmd.is_start && busy_reg;
    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

    assign span_ext = {2'b00, span_reg};
    assign sum_col  = err_col_reg + {2'b00, abs_dx_reg};
    assign sum_row  = err_row_reg + {2'b00, abs_dy_reg};

    always_comb
    begin
        busy_next      = busy_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        step_col_next  = step_col_reg;
        step_row_next  = step_row_reg;
        abs_dx_next    = abs_dx_reg;
        abs_dy_next    = abs_dy_reg;
        span_next      = span_reg;
        err_col_next   = err_col_reg;
        err_row_next   = err_row_reg;
        left_next      = left_reg;
        color_next     = color_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        out_next       = out_reg;

        if (pop && head_cmd.is_start)
        begin
            busy_next     = 1'b1;
            cur_col_next  = head_cmd.start_col;
            cur_row_next  = head_cmd.start_row;
            step_col_next = head_cmd.step_col;
            step_row_next = head_cmd.step_row;
            abs_dx_next   = head_cmd.abs_dx;
            abs_dy_next   = head_cmd.abs_dy;
            span_next     = head_cmd.span;
            err_col_next  = '0;
            err_row_next  = '0;
            left_next     = {1'b0, head_cmd.span} + 2'd2;
            color_next    = head_cmd.color;
        end
        else if (emit)
        begin
            out_valid_next       = 1'b1;
            out_next.point_x     = cur_col_reg;
            out_next.point_y     = cur_row_reg;
            out_next.point_color = color_reg;
            out_next.is_last     = (left_reg == lr_pkg::LEFT_BITS'(1));

            if (sum_col > span_ext)
            begin
                err_col_next = sum_col - span_ext;
                cur_col_next = apply_step(cur_col_reg, step_col_reg);
            end
            else
            begin
                err_col_next = sum_col;
            end

            if (sum_row > span_ext)
            begin
                err_row_next = sum_row - span_ext;
                cur_row_next = apply_step(cur_row_reg, step_row_reg);
            end
            else
            begin
                err_row_next = sum_row;
            end

            if (left_reg != '0)
            begin
                left_next = left_reg - 1'b1;
            end
            busy_next = (left_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            step_col_reg  <= lr_pkg::STEP_NONE;
            step_row_reg  <= lr_pkg::STEP_NONE;
            abs_dx_reg    <= '0;
            abs_dy_reg    <= '0;
            span_reg      <= '0;
            err_col_reg   <= '0;
            err_row_reg   <= '0;
            left_reg      <= '0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            step_col_reg  <= step_col_next;
            step_row_reg  <= step_row_next;
            abs_dx_reg    <= abs_dx_next;
            abs_dy_reg    <= abs_dy_next;
            span_reg      <= span_next;
            err_col_reg   <= err_col_next;
            err_row_reg   <= err_row_next;
            left_reg      <= left_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> (left_reg != '0))
        else $error("line is active with no points left");

    assert property (@(posedge clk) disable iff (!rst_n)
        (err_col_reg <= span_ext) && (err_row_reg <= span_ext))
        else $error("error accumulator exceeds the span");

    assert property (@(posedge clk) disable iff (!rst_n) emit |=> out_valid_reg)
        else $error("next item on an active line gave no pixel");

endmodule

FILE: hw/rtl/line_rasterizer_top.sv
// Top level of the line rasterizer: front setup, command queue and pixel stepper.
// A next item passes the command queue, then the stepper output register, to pix.
// Throughput: one item per cycle while unstalled, set by the stepper's error update.
// A start item yields no pixel; a next item while no line is active yields none.
// Reset (rst_n, asynchronous, active low) empties the queue and clears all line state.
// Depends on lr_pkg, lr_front, lr_queue and lr_back.
module line_rasterizer_top #(
    parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  lr_pkg::req_item_t cmd,
    output logic              pix_valid,
    input  logic              pix_stall,
    output lr_pkg::pix_item_t pix
);

    lr_pkg::lr_cmd_t front_cmd;
    lr_pkg::lr_cmd_t head_cmd;
    logic            queue_full;
    logic            head_valid;
    logic            pop;

    assign cmd_stall = queue_full;

    lr_front u_front (
        .req     (cmd),
        .cmd_out (front_cmd)
    );

    lr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_valid && !queue_full),
        .push_cmd   (front_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix)
    );

endmodule
